// ===== hdl/dedup_block_registry_core_macros.svh =====
// assertion macros for the dedup block registry
`ifndef DEDUP_BLOCK_REGISTRY_CORE_MACROS_SVH
`define DEDUP_BLOCK_REGISTRY_CORE_MACROS_SVH

// implication checked on every clock outside reset
`define DBR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbr implication check failed");

// condition that must never hold outside reset
`define DBR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dbr forbidden condition seen");

`endif

// ===== hdl/dbr_pkg.sv =====
`default_nettype none
package dbr_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int PROBE_LIMIT_DEF   = 256;
    localparam int HASH_BITS         = 32;

    localparam logic [2:0] CMD_LOOKUP   = 3'd0;
    localparam logic [2:0] CMD_REGISTER = 3'd1;
    localparam logic [2:0] CMD_ACQUIRE  = 3'd2;
    localparam logic [2:0] CMD_RELEASE  = 3'd3;
    localparam logic [2:0] CMD_DIRTY    = 3'd4;
    localparam logic [2:0] CMD_HINT     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] hash_low;
        logic [63:0] hash_high;
        logic [51:0] page_address;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        last_reference;
        logic [9:0]  bucket_index;
        logic [51:0] result_address;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] cow_break_total;
        logic [31:0] virtual_pages;
        logic [31:0] physical_pages;
    } rsp_item_t;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [51:0] address;
        logic [31:0] refs;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_EVAL
    } state_t;

    typedef enum logic [1:0] {
        M_FIND,
        M_REG,
        M_SCAN
    } mode_t;

endpackage
`default_nettype wire

// ===== hdl/dbr_ram.sv =====
`default_nettype none
module dbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== hdl/dedup_block_registry_core.sv =====
`default_nettype none
// Page dedup registry: an open-addressed table of TABLE_ENTRIES buckets keyed by a
// 128-bit hash, held in one single-port-write, registered-read RAM and walked by a
// small sequencer one bucket at a time. After reset the block clears the table
// bucket by bucket and stalls commands meanwhile. A hash command visits each bucket
// by a read, then an evaluate and write back, after the low 32 hash bits are
// reduced to a start bucket when TABLE_ENTRIES is not a power of two; release and
// mark dirty scan by address from bucket 0. One command is in flight at a time and
// the next is taken once its result has left the output register.
`include "dedup_block_registry_core_macros.svh"
module dedup_block_registry_core #(
    parameter int TABLE_ENTRIES = dbr_pkg::TABLE_ENTRIES_DEF,
    parameter int PROBE_LIMIT   = dbr_pkg::PROBE_LIMIT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire dbr_pkg::cmd_item_t cmd_item,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output dbr_pkg::rsp_item_t      rsp_item
);

    localparam int AW      = $clog2(TABLE_ENTRIES);
    localparam int CW      = $clog2(PROBE_LIMIT + 1);
    localparam int EW      = $bits(dbr_pkg::entry_t);
    localparam bit POW2    = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam int HASH_BITS_M1 = dbr_pkg::HASH_BITS - 1;

    dbr_pkg::state_t   state_reg, state_next;
    dbr_pkg::mode_t    mode_reg, mode_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [63:0]       klo_reg, klo_next;
    logic [63:0]       khi_reg, khi_next;
    logic [51:0]       addr_reg, addr_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     start_reg, start_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     rem_reg, rem_next;
    logic [4:0]        modcnt_reg, modcnt_next;
    logic [51:0]       raddr_reg, raddr_next;
    logic [31:0]       hits_reg, hits_next;
    logic [31:0]       miss_reg, miss_next;
    logic [31:0]       cow_reg, cow_next;
    logic [31:0]       virt_reg, virt_next;
    logic [31:0]       phys_reg, phys_next;
    logic              rsp_valid_reg, rsp_valid_next;
    dbr_pkg::rsp_item_t rsp_item_reg, rsp_item_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    dbr_pkg::entry_t   wr_entry;
    dbr_pkg::entry_t   rd_entry;
    logic [EW-1:0]     rd_bits;

    logic              finish;
    logic [1:0]        f_status;
    logic              f_last;
    logic [AW-1:0]     f_bucket;
    logic [51:0]       f_raddr;
    logic [AW:0]       mod_t;
    logic [CW-1:0]     cnt_inc;
    logic [AW-1:0]     idx_inc;
    logic              key_hit;

    dbr_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_addr(idx_reg),
        .rd_data(rd_bits)
    );

    assign rd_entry  = dbr_pkg::entry_t'(rd_bits);
    assign cmd_stall = !((state_reg == dbr_pkg::S_IDLE) && !rsp_valid_reg);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign cnt_inc   = CW'(cnt_reg + CW'(1));
    assign idx_inc   = (idx_reg == LAST_IDX) ? '0 : AW'(idx_reg + AW'(1));
    assign mod_t     = {rem_reg, klo_reg[5'd31 - modcnt_reg]};
    assign key_hit   = !rd_entry.dirty && (rd_entry.key_low == klo_reg)
                       && (rd_entry.key_high == khi_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbr_pkg::S_CLEAR;
            mode_reg      <= dbr_pkg::M_FIND;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            modcnt_reg    <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            cow_reg       <= '0;
            virt_reg      <= '0;
            phys_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            modcnt_reg    <= modcnt_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            cow_reg       <= cow_next;
            virt_reg      <= virt_next;
            phys_reg      <= phys_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        klo_reg      <= klo_next;
        khi_reg      <= khi_next;
        addr_reg     <= addr_next;
        start_reg    <= start_next;
        rem_reg      <= rem_next;
        raddr_reg    <= raddr_next;
        rsp_item_reg <= rsp_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        klo_next       = klo_reg;
        khi_next       = khi_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        modcnt_next    = modcnt_reg;
        raddr_next     = raddr_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        cow_next       = cow_reg;
        virt_next      = virt_reg;
        phys_next      = phys_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_item_next  = rsp_item_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_entry       = rd_entry;
        finish         = 1'b0;
        f_status       = dbr_pkg::ST_NOT_FOUND;
        f_last         = 1'b0;
        f_bucket       = '0;
        f_raddr        = '0;

        case (state_reg)
            dbr_pkg::S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_entry = '0;
                idx_next = idx_inc;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = dbr_pkg::S_IDLE;
                end
            end
            dbr_pkg::S_IDLE:
            begin
                if (cmd_valid && !cmd_stall)
                begin
                    cmd_next    = cmd_item.command;
                    klo_next    = cmd_item.hash_low;
                    khi_next    = cmd_item.hash_high;
                    addr_next   = cmd_item.page_address;
                    raddr_next  = '0;
                    cnt_next    = '0;
                    rem_next    = '0;
                    modcnt_next = '0;
                    start_next  = AW'(cmd_item.hash_low[HASH_BITS_M1:0]);
                    idx_next    = AW'(cmd_item.hash_low[HASH_BITS_M1:0]);
                    case (cmd_item.command)
                        dbr_pkg::CMD_LOOKUP, dbr_pkg::CMD_ACQUIRE, dbr_pkg::CMD_HINT:
                        begin
                            mode_next  = dbr_pkg::M_FIND;
                            state_next = POW2 ? dbr_pkg::S_READ : dbr_pkg::S_MOD;
                            if (cmd_item.command == dbr_pkg::CMD_HINT
                                && cmd_item.page_address == '0)
                            begin
                                state_next = dbr_pkg::S_IDLE;
                                finish     = 1'b1;
                            end
                        end
                        dbr_pkg::CMD_REGISTER:
                        begin
                            mode_next  = dbr_pkg::M_REG;
                            state_next = POW2 ? dbr_pkg::S_READ : dbr_pkg::S_MOD;
                        end
                        dbr_pkg::CMD_RELEASE, dbr_pkg::CMD_DIRTY:
                        begin
                            mode_next  = dbr_pkg::M_SCAN;
                            idx_next   = '0;
                            state_next = dbr_pkg::S_READ;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            dbr_pkg::S_MOD:
            begin
                // restoring remainder, one hash bit a cycle
                if (mod_t >= (AW + 1)'(TABLE_ENTRIES))
                begin
                    rem_next = AW'(mod_t - (AW + 1)'(TABLE_ENTRIES));
                end
                else
                begin
                    rem_next = AW'(mod_t);
                end
                modcnt_next = modcnt_reg + 5'd1;
                if (modcnt_reg == 5'd31)
                begin
                    start_next = rem_next;
                    idx_next   = rem_next;
                    state_next = dbr_pkg::S_READ;
                end
            end
            dbr_pkg::S_READ:
            begin
                state_next = dbr_pkg::S_EVAL;
            end
            dbr_pkg::S_EVAL:
            begin
                state_next = dbr_pkg::S_READ;
                case (mode_reg)
                    dbr_pkg::M_FIND:
                    begin
                        if (rd_entry.valid && key_hit
                            && (cmd_reg == dbr_pkg::CMD_LOOKUP))
                        begin
                            finish   = 1'b1;
                            f_status = dbr_pkg::ST_OK;
                            f_bucket = idx_reg;
                        end
                        else if (rd_entry.valid && key_hit && rd_entry.refs != '0)
                        begin
                            wr_en         = 1'b1;
                            wr_entry.refs = rd_entry.refs + 32'd1;
                            hits_next     = hits_reg + 32'd1;
                            virt_next     = virt_reg + 32'd1;
                            if (cmd_reg == dbr_pkg::CMD_HINT && rd_entry.address == '0)
                            begin
                                mode_next = dbr_pkg::M_REG;
                                idx_next  = start_reg;
                                cnt_next  = '0;
                            end
                            else
                            begin
                                finish   = 1'b1;
                                f_status = dbr_pkg::ST_OK;
                                f_raddr  = rd_entry.address;
                            end
                        end
                        else if (!rd_entry.valid || key_hit || cnt_inc == CW'(PROBE_LIMIT))
                        begin
                            if (cmd_reg == dbr_pkg::CMD_HINT)
                            begin
                                mode_next = dbr_pkg::M_REG;
                                idx_next  = start_reg;
                                cnt_next  = '0;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_inc;
                            idx_next = idx_inc;
                        end
                    end
                    dbr_pkg::M_REG:
                    begin
                        if (!rd_entry.valid)
                        begin
                            wr_en             = 1'b1;
                            wr_entry.valid    = 1'b1;
                            wr_entry.dirty    = 1'b0;
                            wr_entry.key_low  = klo_reg;
                            wr_entry.key_high = khi_reg;
                            wr_entry.address  = addr_reg;
                            wr_entry.refs     = 32'd1;
                            miss_next         = miss_reg + 32'd1;
                            virt_next         = virt_reg + 32'd1;
                            phys_next         = phys_reg + 32'd1;
                            finish            = 1'b1;
                            f_status          = dbr_pkg::ST_OK;
                            if (cmd_reg == dbr_pkg::CMD_HINT)
                            begin
                                f_raddr = addr_reg;
                            end
                            else
                            begin
                                f_bucket = idx_reg;
                            end
                        end
                        else if (cnt_inc == CW'(PROBE_LIMIT))
                        begin
                            finish   = 1'b1;
                            f_status = dbr_pkg::ST_FULL;
                            if (cmd_reg == dbr_pkg::CMD_HINT)
                            begin
                                f_raddr = addr_reg;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_inc;
                            idx_next = idx_inc;
                        end
                    end
                    default:
                    begin
                        if (rd_entry.valid && rd_entry.address == addr_reg)
                        begin
                            finish = 1'b1;
                            if (cmd_reg == dbr_pkg::CMD_DIRTY)
                            begin
                                wr_en          = 1'b1;
                                wr_entry.dirty = 1'b1;
                                cow_next       = cow_reg + 32'd1;
                                f_status       = dbr_pkg::ST_OK;
                            end
                            else if (rd_entry.refs == '0)
                            begin
                                f_status = dbr_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_entry.refs = rd_entry.refs - 32'd1;
                                virt_next     = virt_reg - 32'd1;
                                f_status      = dbr_pkg::ST_OK;
                                if (rd_entry.refs == 32'd1)
                                begin
                                    wr_entry.valid = 1'b0;
                                    wr_entry.dirty = 1'b0;
                                    phys_next      = phys_reg - 32'd1;
                                    f_last         = 1'b1;
                                end
                            end
                        end
                        else if (idx_reg == LAST_IDX)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end
                endcase
                if (finish)
                begin
                    state_next = dbr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dbr_pkg::S_IDLE;
            end
        endcase

        if (finish)
        begin
            rsp_valid_next                = 1'b1;
            rsp_item_next.status          = f_status;
            rsp_item_next.last_reference  = f_last;
            rsp_item_next.bucket_index    = 10'(f_bucket);
            rsp_item_next.result_address  = f_raddr;
            rsp_item_next.hit_total       = hits_next;
            rsp_item_next.miss_total      = miss_next;
            rsp_item_next.cow_break_total = cow_next;
            rsp_item_next.virtual_pages   = virt_next;
            rsp_item_next.physical_pages  = phys_next;
        end
    end

    `DBR_ASSERT_IMP(a_rsp_only_idle, rsp_valid_reg, state_reg == dbr_pkg::S_IDLE)
    `DBR_ASSERT_IMP(a_no_rsp_in_clear, state_reg == dbr_pkg::S_CLEAR, !rsp_valid_reg)
    `DBR_ASSERT_NEVER(a_last_needs_ok,
        rsp_valid_reg && rsp_item_reg.last_reference && rsp_item_reg.status != dbr_pkg::ST_OK)
    `DBR_ASSERT_IMP(a_take_only_idle, cmd_valid && !cmd_stall, state_reg == dbr_pkg::S_IDLE)

endmodule
`default_nettype wire

// ===== dv/dedup_block_registry_core_tb.sv =====
`timescale 1ns / 100ps
module dedup_block_registry_core_tb;

    localparam int NBUCKETS = 1024;
    localparam int PROBE_WINDOW = 256;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    dbr_pkg::cmd_item_t cmd_item;
    logic rsp_valid;
    logic rsp_stall;
    dbr_pkg::rsp_item_t rsp_item;
    logic cmd_taken;

    dedup_block_registry_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item(cmd_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item(rsp_item)
    );

    // shadow registry
    bit          tbl_used [NBUCKETS];
    bit          tbl_dirty [NBUCKETS];
    logic [63:0] tbl_klo [NBUCKETS];
    logic [63:0] tbl_khi [NBUCKETS];
    logic [51:0] tbl_addr [NBUCKETS];
    logic [31:0] tbl_refs [NBUCKETS];
    logic [31:0] hits_cnt, misses_cnt, cow_cnt, vpages_cnt, ppages_cnt;

    dbr_pkg::cmd_item_t pending_cmds[$];
    dbr_pkg::rsp_item_t expected_rsps[$];
    int mismatches;
    bit quiet_mode;
    bit hold_sender;

    // pool of keys and pages so that sequences hit earlier entries
    logic [63:0] key_lo_pool[$];
    logic [63:0] key_hi_pool[$];
    logic [51:0] page_pool[$];

    function automatic int find_clean(logic [63:0] klo, logic [63:0] khi);
        int s;
        int b;
        s = int'(klo[9:0]);
        for (int i = 0; i < PROBE_WINDOW; i++)
        begin
            b = (s + i) % NBUCKETS;
            if (!tbl_used[b])
                return -1;
            if (!tbl_dirty[b] && tbl_klo[b] == klo && tbl_khi[b] == khi)
                return b;
        end
        return -1;
    endfunction

    function automatic int claim_bucket(logic [63:0] klo, logic [63:0] khi,
                                        logic [51:0] addr);
        int s;
        int b;
        s = int'(klo[9:0]);
        for (int i = 0; i < PROBE_WINDOW; i++)
        begin
            b = (s + i) % NBUCKETS;
            if (!tbl_used[b])
            begin
                tbl_used[b] = 1;
                tbl_dirty[b] = 0;
                tbl_klo[b] = klo;
                tbl_khi[b] = khi;
                tbl_addr[b] = addr;
                tbl_refs[b] = 1;
                misses_cnt++;
                vpages_cnt++;
                ppages_cnt++;
                return b;
            end
        end
        return -1;
    endfunction

    function automatic logic [51:0] share_page(logic [63:0] klo, logic [63:0] khi);
        int b;
        b = find_clean(klo, khi);
        if (b < 0 || tbl_refs[b] == 0)
            return '0;
        tbl_refs[b]++;
        hits_cnt++;
        vpages_cnt++;
        return tbl_addr[b];
    endfunction

    function automatic int scan_page(logic [51:0] addr);
        for (int b = 0; b < NBUCKETS; b++)
            if (tbl_used[b] && tbl_addr[b] == addr)
                return b;
        return -1;
    endfunction

    function automatic dbr_pkg::rsp_item_t registry_outcome(dbr_pkg::cmd_item_t c);
        dbr_pkg::rsp_item_t r;
        int b;
        r = '0;
        r.status = dbr_pkg::ST_NOT_FOUND;
        case (c.command)
            dbr_pkg::CMD_LOOKUP:
            begin
                b = find_clean(c.hash_low, c.hash_high);
                if (b >= 0)
                begin
                    r.status = dbr_pkg::ST_OK;
                    r.bucket_index = 10'(b);
                end
            end
            dbr_pkg::CMD_REGISTER:
            begin
                b = claim_bucket(c.hash_low, c.hash_high, c.page_address);
                if (b >= 0)
                begin
                    r.status = dbr_pkg::ST_OK;
                    r.bucket_index = 10'(b);
                end
                else
                    r.status = dbr_pkg::ST_FULL;
            end
            dbr_pkg::CMD_ACQUIRE:
            begin
                b = find_clean(c.hash_low, c.hash_high);
                if (b >= 0 && tbl_refs[b] != 0)
                    r.status = dbr_pkg::ST_OK;
                r.result_address = share_page(c.hash_low, c.hash_high);
            end
            dbr_pkg::CMD_RELEASE:
            begin
                b = scan_page(c.page_address);
                if (b >= 0)
                begin
                    if (tbl_refs[b] == 0)
                        r.status = dbr_pkg::ST_UNDERFLOW;
                    else
                    begin
                        tbl_refs[b]--;
                        vpages_cnt--;
                        r.status = dbr_pkg::ST_OK;
                        if (tbl_refs[b] == 0)
                        begin
                            tbl_used[b] = 0;
                            tbl_dirty[b] = 0;
                            ppages_cnt--;
                            r.last_reference = 1;
                        end
                    end
                end
            end
            dbr_pkg::CMD_DIRTY:
            begin
                b = scan_page(c.page_address);
                if (b >= 0)
                begin
                    tbl_dirty[b] = 1;
                    cow_cnt++;
                    r.status = dbr_pkg::ST_OK;
                end
            end
            dbr_pkg::CMD_HINT:
            begin
                if (c.page_address != 0)
                begin
                    r.result_address = share_page(c.hash_low, c.hash_high);
                    if (r.result_address != 0)
                        r.status = dbr_pkg::ST_OK;
                    else
                    begin
                        b = claim_bucket(c.hash_low, c.hash_high, c.page_address);
                        r.status = (b >= 0) ? dbr_pkg::ST_OK : dbr_pkg::ST_FULL;
                        r.result_address = c.page_address;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.hit_total = hits_cnt;
        r.miss_total = misses_cnt;
        r.cow_break_total = cow_cnt;
        r.virtual_pages = vpages_cnt;
        r.physical_pages = ppages_cnt;
        return r;
    endfunction

    function automatic dbr_pkg::cmd_item_t make_cmd(logic [2:0] op, logic [63:0] klo,
                                                    logic [63:0] khi, logic [51:0] addr);
        dbr_pkg::cmd_item_t c;
        c.command = op;
        c.hash_low = klo;
        c.hash_high = khi;
        c.page_address = addr;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic dbr_pkg::cmd_item_t random_cmd();
        dbr_pkg::cmd_item_t c;
        int k;
        int sel;
        sel = $urandom_range(0, 99);
        c.hash_low = rand64();
        c.hash_high = rand64();
        c.page_address = {20'($urandom_range(0, 1048575)), $urandom};
        if (key_lo_pool.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            k = $urandom_range(0, key_lo_pool.size() - 1);
            c.hash_low = key_lo_pool[k];
            c.hash_high = key_hi_pool[k];
        end
        else if ($urandom_range(0, 2) == 0)
            // crowd a few buckets to exercise probing
            c.hash_low[9:0] = 10'($urandom_range(0, 7));
        if (page_pool.size() > 0 && $urandom_range(0, 2) != 0)
            c.page_address = page_pool[$urandom_range(0, page_pool.size() - 1)];
        if (sel < 20)
            c.command = dbr_pkg::CMD_REGISTER;
        else if (sel < 40)
            c.command = dbr_pkg::CMD_ACQUIRE;
        else if (sel < 58)
            c.command = dbr_pkg::CMD_RELEASE;
        else if (sel < 65)
            c.command = dbr_pkg::CMD_DIRTY;
        else if (sel < 85)
            c.command = dbr_pkg::CMD_HINT;
        else if (sel < 97)
            c.command = dbr_pkg::CMD_LOOKUP;
        else
            c.command = 3'($urandom_range(6, 7));
        if (c.command == dbr_pkg::CMD_REGISTER || c.command == dbr_pkg::CMD_HINT)
        begin
            if (key_lo_pool.size() < 40)
            begin
                key_lo_pool.push_back(c.hash_low);
                key_hi_pool.push_back(c.hash_high);
            end
            if (page_pool.size() < 60)
                page_pool.push_back(c.page_address);
        end
        return c;
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 0;
            cmd_item <= '0;
        end
        else if (!cmd_valid || cmd_taken)
        begin
            if (pending_cmds.size() > 0 && !hold_sender
                && (quiet_mode || $urandom_range(0, 99) >= 6))
            begin
                cmd_item <= pending_cmds.pop_front();
                cmd_valid <= 1;
            end
            else
                cmd_valid <= 0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 0;
        else
            rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < 6);
    end

    // prediction at acceptance, then response check
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            expected_rsps.push_back(registry_outcome(cmd_item));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", rsp_item);
            end
            else
            begin
                dbr_pkg::rsp_item_t want;
                want = expected_rsps.pop_front();
                if (rsp_item !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, rsp_item);
                end
            end
        end
    end

    initial
    begin
        logic [63:0] klo;
        logic [63:0] khi;
        logic [51:0] pg;
        for (int b = 0; b < NBUCKETS; b++)
        begin
            tbl_used[b] = 0;
            tbl_dirty[b] = 0;
            tbl_klo[b] = '0;
            tbl_khi[b] = '0;
            tbl_addr[b] = '0;
            tbl_refs[b] = '0;
        end
        hits_cnt = 0;
        misses_cnt = 0;
        cow_cnt = 0;
        vpages_cnt = 0;
        ppages_cnt = 0;
        mismatches = 0;
        quiet_mode = 0;
        hold_sender = 0;
        rst_n = 0;

        klo = 64'hFFFF_FFFF_FFFF_FFFF;
        khi = 64'hFFFF_FFFF_FFFF_FFFF;
        pg = 52'hF_FFFF_FFFF_FFFF;
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_LOOKUP, klo, khi, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_ACQUIRE, klo, khi, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_REGISTER, klo, khi, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_LOOKUP, klo, khi, '0));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_ACQUIRE, klo, khi, '0));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_REGISTER, klo, khi, '0));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_HINT, klo, khi, 52'h5));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_DIRTY, '0, '0, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_DIRTY, '0, '0, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_LOOKUP, klo, khi, '0));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_RELEASE, '0, '0, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_RELEASE, '0, '0, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_RELEASE, '0, '0, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_RELEASE, '0, '0, pg));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_RELEASE, '0, '0, 52'h123));
        // zero-address entry makes the hint fall back to register
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_REGISTER, '0, '0, '0));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_HINT, '0, '0, 52'h77));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_HINT, '0, '0, '0));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_HINT, 64'h3FF, 64'h1, 52'h9));
        pending_cmds.push_back(make_cmd(dbr_pkg::CMD_HINT, 64'h3FF, 64'h1, 52'hA));
        pending_cmds.push_back(make_cmd(3'd6, klo, khi, pg));
        pending_cmds.push_back(make_cmd(3'd7, '0, '0, '0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        while (pending_cmds.size() > 0)
            @(posedge clk);
        // sender holds off until everything is back
        hold_sender = 1;
        while (expected_rsps.size() > 0 || cmd_valid)
            @(posedge clk);
        hold_sender = 0;

        for (int n = 0; n < 1400; n++)
        begin
            if (n == 300)
                quiet_mode = 1;
            if (n == 500)
                quiet_mode = 0;
            pending_cmds.push_back(random_cmd());
            while (pending_cmds.size() > 8)
                @(posedge clk);
        end
        while (pending_cmds.size() > 0 || cmd_valid)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("dedup_block_registry_core regression: pass");
        else
            $display("dedup_block_registry_core regression: fail");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("dedup_block_registry_core regression: fail");
        $finish;
    end

endmodule
